// ===== design/etm_pkg.sv =====
// Shared types, constants and tables for the Euler transform matrix block.
`timescale 1ns / 1ps

package etm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS = 16;

  localparam int ATAN_LEN = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int RUN_LEN = (CORDIC_ITERS > DIV_STEPS) ? CORDIC_ITERS : DIV_STEPS;
  localparam int CNT_W = $clog2(RUN_LEN + 1);

  localparam int TRIG_W = 34;
  localparam int RED_W = 36;

  localparam logic signed [RED_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [RED_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic                     command;
    logic signed [TRIG_W-1:0] ang_x;
    logic signed [TRIG_W-1:0] ang_y;
    logic signed [TRIG_W-1:0] ang_z;
    logic                     flip_x;
    logic                     flip_y;
    logic                     flip_z;
    logic signed [31:0]       scale_x;
    logic signed [31:0]       scale_y;
    logic signed [31:0]       scale_z;
    logic signed [31:0]       shift_x;
    logic signed [31:0]       shift_y;
    logic signed [31:0]       shift_z;
  } work_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_EMIT
  } back_state_t;

  typedef enum logic [4:0] {
    OP_S1S2,
    OP_C1S2,
    OP_C3S1,
    OP_C1C3,
    OP_C2S3,
    OP_C2C3,
    OP_C2S1,
    OP_C1C2,
    OP_S1S3,
    OP_C1S3,
    OP_S1S2S3,
    OP_C1S2S3,
    OP_C3S1S2,
    OP_C1C3S2,
    OP_E00,
    OP_E01,
    OP_E02,
    OP_E10,
    OP_E11,
    OP_E12,
    OP_E20,
    OP_E21,
    OP_E22
  } mul_op_t;

  // Truncated Q30 arctangent of 2^-i.
  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [TRIG_W-1:0] v;
    case (i)
      5'd0:    v = 34'sh3243F6A8;
      5'd1:    v = 34'sh1DAC6705;
      5'd2:    v = 34'sh0FADBAFC;
      5'd3:    v = 34'sh07F56EA6;
      5'd4:    v = 34'sh03FEAB76;
      5'd5:    v = 34'sh01FFD55B;
      5'd6:    v = 34'sh00FFFAAA;
      5'd7:    v = 34'sh007FFF55;
      5'd8:    v = 34'sh003FFFEA;
      5'd9:    v = 34'sh001FFFFD;
      5'd10:   v = 34'sh000FFFFF;
      5'd11:   v = 34'sh0007FFFF;
      5'd12:   v = 34'sh0003FFFF;
      5'd13:   v = 34'sh0001FFFF;
      5'd14:   v = 34'sh0000FFFF;
      5'd15:   v = 34'sh00007FFF;
      5'd16:   v = 34'sh00003FFF;
      5'd17:   v = 34'sh00001FFF;
      5'd18:   v = 34'sh00000FFF;
      5'd19:   v = 34'sh000007FF;
      5'd20:   v = 34'sh000003FF;
      5'd21:   v = 34'sh000001FF;
      5'd22:   v = 34'sh000000FF;
      5'd23:   v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/etm_front.sv =====
// Front end: accepts input words and range-reduces the three angles.
`timescale 1ns / 1ps

module etm_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic signed [15:0]  angle_x,
  input  logic signed [15:0]  angle_y,
  input  logic signed [15:0]  angle_z,
  input  logic signed [31:0]  scale_x,
  input  logic signed [31:0]  scale_y,
  input  logic signed [31:0]  scale_z,
  input  logic signed [31:0]  shift_x,
  input  logic signed [31:0]  shift_y,
  input  logic signed [31:0]  shift_z,
  input  logic                full,
  output logic                push,
  output etm_pkg::work_t      push_data
);
  import etm_pkg::*;

  // Q4.12 -> Q30, fold into [-pi/2, pi/2]; returns {flip, angle}.
  function automatic logic [TRIG_W:0] reduce(input logic signed [15:0] ang);
    logic signed [RED_W-1:0] a;
    logic                    flip;
    a = {{2{ang[15]}}, ang, 18'b0};
    flip = 1'b0;
    if (a > PI_Q30) a = a - TWO_PI_Q30;
    if (a < -PI_Q30) a = a + TWO_PI_Q30;
    if (a > HALF_PI_Q30) begin
      a = a - PI_Q30;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a = a + PI_Q30;
      flip = 1'b1;
    end
    return {flip, a[TRIG_W-1:0]};
  endfunction

  logic [TRIG_W:0] red_x, red_y, red_z;

  assign red_x = reduce(angle_x);
  assign red_y = reduce(angle_y);
  assign red_z = reduce(angle_z);

  assign in_stall = full;
  assign push = in_valid && !full;

  always_comb begin
    push_data.command = command;
    push_data.ang_x = red_x[TRIG_W-1:0];
    push_data.ang_y = red_y[TRIG_W-1:0];
    push_data.ang_z = red_z[TRIG_W-1:0];
    push_data.flip_x = red_x[TRIG_W];
    push_data.flip_y = red_y[TRIG_W];
    push_data.flip_z = red_z[TRIG_W];
    push_data.scale_x = scale_x;
    push_data.scale_y = scale_y;
    push_data.scale_z = scale_z;
    push_data.shift_x = shift_x;
    push_data.shift_y = shift_y;
    push_data.shift_z = shift_z;
  end

endmodule

// ===== design/etm_queue.sv =====
// Two-entry queue between the front end and the matrix engine.
`timescale 1ns / 1ps

module etm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  etm_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output etm_pkg::work_t pop_data,
  output logic           empty
);
  import etm_pkg::*;

  work_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/etm_back.sv =====
// Matrix engine: CORDIC lanes, reciprocal dividers, shared multiplier, column output.
`timescale 1ns / 1ps

module etm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  output logic               pop,
  input  etm_pkg::work_t     pop_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         column,
  output logic signed [31:0] entry_0,
  output logic signed [31:0] entry_1,
  output logic signed [31:0] entry_2,
  output logic signed [31:0] entry_3,
  output logic               final_column,
  output logic               divide_error
);
  import etm_pkg::*;

  back_state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  work_t job;

  // lanes: 0 = angle_y, 1 = angle_x, 2 = angle_z
  logic signed [TRIG_W-1:0] cx [3];
  logic signed [TRIG_W-1:0] cy [3];
  logic signed [TRIG_W-1:0] ca [3];
  logic signed [TRIG_W-1:0] nx [3];
  logic signed [TRIG_W-1:0] ny [3];
  logic signed [TRIG_W-1:0] na [3];
  logic [4:0] iter;

  // reciprocal lanes: one per scale
  logic [31:0]          dmag [3];
  logic [31:0]          drem [3];
  logic [DIV_STEPS-1:0] quo [3];
  logic [32:0]          r2 [3];
  logic [31:0]          nrem [3];
  logic                 qbit [3];
  logic signed [31:0]   scl [3];
  logic signed [31:0]   fac [3];
  logic                 ferr [3];
  logic signed [31:0]   fac_new [3];
  logic                 ferr_new [3];
  logic [63:0]          q64 [3];

  logic signed [TRIG_W-1:0] s1, c1, s2, c2, s3, c3;
  logic signed [TRIG_W-1:0] m_s1s2, m_c1s2, m_c3s1, m_c1c3, m_c2s3, m_c2c3, m_c2s1;
  logic signed [TRIG_W-1:0] m_c1c2, m_s1s3, m_c1s3, m_s1s2s3, m_c1s2s3, m_c3s1s2, m_c1c3s2;
  logic signed [TRIG_W-1:0] rot00, rot01, rot02, rot10, rot11, rot12, rot20, rot21, rot22;

  logic [4:0]               op_step;
  logic                     issue;
  logic signed [TRIG_W-1:0] mul_a, mul_b;
  logic signed [67:0]       prod;
  logic signed [67:0]       rnd_full;
  logic signed [37:0]       rnd;
  logic signed [31:0]       rnd_sat;
  logic                     wb_valid;
  mul_op_t                  wb_op;

  logic signed [31:0] ent [3][3];
  logic [1:0]         ecol;
  logic [1:0]         last_col;
  logic               load;
  logic               emit_req;
  logic               run_done;
  logic               mul_done;

  assign iter = cnt[4:0];
  assign run_done = (cnt == CNT_W'(RUN_LEN));
  assign mul_done = wb_valid && (wb_op == OP_E22);
  assign last_col = job.command ? 2'd2 : 2'd3;
  assign load = emit_req && (!out_valid || !out_stall);

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!empty) state_next = ST_RUN;
      ST_RUN:  if (run_done) state_next = ST_MUL;
      ST_MUL:  if (mul_done) state_next = ST_EMIT;
      ST_EMIT: if (load && (ecol == last_col)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    issue = 1'b0;
    emit_req = 1'b0;
    case (state)
      ST_IDLE: pop = !empty;
      ST_MUL:  issue = (op_step <= OP_E22);
      ST_EMIT: emit_req = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // CORDIC and divider steps
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (ca[k] >= 0) begin
        nx[k] = cx[k] - (cy[k] >>> iter);
        ny[k] = cy[k] + (cx[k] >>> iter);
        na[k] = ca[k] - atan_q30(iter);
      end else begin
        nx[k] = cx[k] + (cy[k] >>> iter);
        ny[k] = cy[k] - (cx[k] >>> iter);
        na[k] = ca[k] + atan_q30(iter);
      end
      // dividend is 2^(2*FRAC_BITS): a single one at the top
      r2[k] = {drem[k], (cnt == '0)};
      if (r2[k] >= {1'b0, dmag[k]}) begin
        nrem[k] = r2[k][31:0] - dmag[k];
        qbit[k] = 1'b1;
      end else begin
        nrem[k] = r2[k][31:0];
        qbit[k] = 1'b0;
      end
    end
  end

  assign scl[0] = job.scale_x;
  assign scl[1] = job.scale_y;
  assign scl[2] = job.scale_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q64[k] = {{(64 - DIV_STEPS){1'b0}}, quo[k]};
      ferr_new[k] = 1'b0;
      if (!job.command) begin
        fac_new[k] = scl[k];
      end else if (scl[k] == '0) begin
        fac_new[k] = 32'sh7FFFFFFF;
        ferr_new[k] = 1'b1;
      end else if (!scl[k][31]) begin
        fac_new[k] = (q64[k] > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q64[k][31:0];
      end else begin
        fac_new[k] = (q64[k] > 64'h80000000) ? 32'sh80000000 : 32'(-q64[k][31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_data;
      cnt <= '0;
      for (int k = 0; k < 3; k++) begin
        cx[k] <= GAIN_Q30;
        cy[k] <= '0;
        drem[k] <= '0;
        quo[k] <= '0;
      end
      ca[0] <= pop_data.ang_y;
      ca[1] <= pop_data.ang_x;
      ca[2] <= pop_data.ang_z;
      dmag[0] <= pop_data.scale_x[31] ? 32'(-pop_data.scale_x) : pop_data.scale_x;
      dmag[1] <= pop_data.scale_y[31] ? 32'(-pop_data.scale_y) : pop_data.scale_y;
      dmag[2] <= pop_data.scale_z[31] ? 32'(-pop_data.scale_z) : pop_data.scale_z;
    end else if (state == ST_RUN) begin
      if (!run_done) cnt <= cnt + 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (cnt < CNT_W'(CORDIC_ITERS)) begin
          cx[k] <= nx[k];
          cy[k] <= ny[k];
          ca[k] <= na[k];
        end
        if (cnt < CNT_W'(DIV_STEPS)) begin
          drem[k] <= nrem[k];
          quo[k] <= {quo[k][DIV_STEPS-2:0], qbit[k]};
        end
      end
      if (run_done) begin
        s1 <= job.flip_y ? -cy[0] : cy[0];
        c1 <= job.flip_y ? -cx[0] : cx[0];
        s2 <= job.flip_x ? -cy[1] : cy[1];
        c2 <= job.flip_x ? -cx[1] : cx[1];
        s3 <= job.flip_z ? -cy[2] : cy[2];
        c3 <= job.flip_z ? -cx[2] : cx[2];
        for (int k = 0; k < 3; k++) begin
          fac[k] <= fac_new[k];
          ferr[k] <= ferr_new[k];
        end
      end
    end
  end

  // rotation terms
  assign rot00 = m_c1c3 + m_s1s2s3;
  assign rot01 = m_c2s3;
  assign rot02 = m_c1s2s3 - m_c3s1;
  assign rot10 = m_c3s1s2 - m_c1s3;
  assign rot11 = m_c2c3;
  assign rot12 = m_c1c3s2 + m_s1s3;
  assign rot20 = m_c2s1;
  assign rot21 = -s2;
  assign rot22 = m_c1c2;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mul_op_t'(op_step))
      OP_S1S2:   begin mul_a = s1;     mul_b = s2; end
      OP_C1S2:   begin mul_a = c1;     mul_b = s2; end
      OP_C3S1:   begin mul_a = c3;     mul_b = s1; end
      OP_C1C3:   begin mul_a = c1;     mul_b = c3; end
      OP_C2S3:   begin mul_a = c2;     mul_b = s3; end
      OP_C2C3:   begin mul_a = c2;     mul_b = c3; end
      OP_C2S1:   begin mul_a = c2;     mul_b = s1; end
      OP_C1C2:   begin mul_a = c1;     mul_b = c2; end
      OP_S1S3:   begin mul_a = s1;     mul_b = s3; end
      OP_C1S3:   begin mul_a = c1;     mul_b = s3; end
      OP_S1S2S3: begin mul_a = m_s1s2; mul_b = s3; end
      OP_C1S2S3: begin mul_a = m_c1s2; mul_b = s3; end
      OP_C3S1S2: begin mul_a = m_c3s1; mul_b = s2; end
      OP_C1C3S2: begin mul_a = m_c1c3; mul_b = s2; end
      OP_E00:    begin mul_a = TRIG_W'(fac[0]); mul_b = rot00; end
      OP_E01:    begin mul_a = TRIG_W'(fac[0]); mul_b = rot01; end
      OP_E02:    begin mul_a = TRIG_W'(fac[0]); mul_b = rot02; end
      OP_E10:    begin mul_a = TRIG_W'(fac[1]); mul_b = rot10; end
      OP_E11:    begin mul_a = TRIG_W'(fac[1]); mul_b = rot11; end
      OP_E12:    begin mul_a = TRIG_W'(fac[1]); mul_b = rot12; end
      OP_E20:    begin mul_a = TRIG_W'(fac[2]); mul_b = rot20; end
      OP_E21:    begin mul_a = TRIG_W'(fac[2]); mul_b = rot21; end
      OP_E22:    begin mul_a = TRIG_W'(fac[2]); mul_b = rot22; end
      default:   ;
    endcase
  end

  // round half up, then shift out Q30
  assign rnd_full = prod + (68'sd1 <<< 29);
  assign rnd = rnd_full[67:30];
  assign rnd_sat = (rnd > 38'sd2147483647) ? 32'sh7FFFFFFF :
                   (rnd < -38'sd2147483648) ? 32'sh80000000 : rnd[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      op_step <= '0;
    end else begin
      wb_valid <= issue;
      if (run_done && (state == ST_RUN)) op_step <= '0;
      else if (issue) op_step <= op_step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    wb_op <= mul_op_t'(op_step);
    if (wb_valid) begin
      case (wb_op)
        OP_S1S2:   m_s1s2 <= rnd[TRIG_W-1:0];
        OP_C1S2:   m_c1s2 <= rnd[TRIG_W-1:0];
        OP_C3S1:   m_c3s1 <= rnd[TRIG_W-1:0];
        OP_C1C3:   m_c1c3 <= rnd[TRIG_W-1:0];
        OP_C2S3:   m_c2s3 <= rnd[TRIG_W-1:0];
        OP_C2C3:   m_c2c3 <= rnd[TRIG_W-1:0];
        OP_C2S1:   m_c2s1 <= rnd[TRIG_W-1:0];
        OP_C1C2:   m_c1c2 <= rnd[TRIG_W-1:0];
        OP_S1S3:   m_s1s3 <= rnd[TRIG_W-1:0];
        OP_C1S3:   m_c1s3 <= rnd[TRIG_W-1:0];
        OP_S1S2S3: m_s1s2s3 <= rnd[TRIG_W-1:0];
        OP_C1S2S3: m_c1s2s3 <= rnd[TRIG_W-1:0];
        OP_C3S1S2: m_c3s1s2 <= rnd[TRIG_W-1:0];
        OP_C1C3S2: m_c1c3s2 <= rnd[TRIG_W-1:0];
        OP_E00:    ent[0][0] <= rnd_sat;
        OP_E01:    ent[0][1] <= rnd_sat;
        OP_E02:    ent[0][2] <= rnd_sat;
        OP_E10:    ent[1][0] <= rnd_sat;
        OP_E11:    ent[1][1] <= rnd_sat;
        OP_E12:    ent[1][2] <= rnd_sat;
        OP_E20:    ent[2][0] <= rnd_sat;
        OP_E21:    ent[2][1] <= rnd_sat;
        OP_E22:    ent[2][2] <= rnd_sat;
        default:   ;
      endcase
    end
  end

  // output register, one column per word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ecol <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        ecol <= (ecol == last_col) ? 2'd0 : ecol + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      column <= ecol;
      final_column <= (ecol == last_col);
      if (ecol == 2'd3) begin
        entry_0 <= job.shift_x;
        entry_1 <= job.shift_y;
        entry_2 <= job.shift_z;
        entry_3 <= 32'(64'd1 << FRAC_BITS);
        divide_error <= 1'b0;
      end else begin
        entry_0 <= ent[ecol][0];
        entry_1 <= ent[ecol][1];
        entry_2 <= ent[ecol][2];
        entry_3 <= '0;
        divide_error <= ferr[ecol];
      end
    end
  end

endmodule

// ===== design/euler_transform_matrix.sv =====
// Top level: Tait-Bryan YXZ model and normal matrix builder.
// A word passes the queue, the CORDIC and reciprocal run, the shared multiplier
// and the output register before its first column appears. The engine works on
// one transform at a time and pops a new word only when idle, after the last column;
// its rate is set by the bit-serial reciprocal lanes and the 23-op shared multiplier.
// The two-entry queue takes new words while the engine works.
// Synchronous active-high reset clears the queue, sequencer and output valid.
`timescale 1ns / 1ps

module euler_transform_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         column,
  output logic signed [31:0] entry_0,
  output logic signed [31:0] entry_1,
  output logic signed [31:0] entry_2,
  output logic signed [31:0] entry_3,
  output logic               final_column,
  output logic               divide_error
);
  import etm_pkg::*;

  work_t push_data, pop_data;
  logic  push, pop, full, empty;

  etm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .angle_z   (angle_z),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .scale_z   (scale_z),
    .shift_x   (shift_x),
    .shift_y   (shift_y),
    .shift_z   (shift_z),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  etm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  etm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column       (column),
    .entry_0      (entry_0),
    .entry_1      (entry_1),
    .entry_2      (entry_2),
    .entry_3      (entry_3),
    .final_column (final_column),
    .divide_error (divide_error)
  );

endmodule
